// ===== rtl/core/pfbls_pkg.sv =====
`timescale 1ns / 1ps
package pfbls_pkg;
	localparam int unsigned ROWS_DEF            = 100;
	localparam int unsigned FLASH_PERIOD_MS_DEF = 100;
	localparam int unsigned BURST_TIME_MS_DEF   = 5000;
	localparam int unsigned FLASH_TIME_MS_DEF   = 2000;

	localparam logic [2:0] REG_LOW_CUTOFF    = 3'd0;
	localparam logic [2:0] REG_BURST_LEVEL   = 3'd1;
	localparam logic [2:0] REG_FLASH_LEVEL   = 3'd2;
	localparam logic [2:0] REG_FILL_COLOR    = 3'd3;
	localparam logic [2:0] REG_DRAIN_COLOR   = 3'd4;
	localparam logic [2:0] REG_STEP_ROWS     = 3'd5;
	localparam logic [2:0] REG_SLOW_INTERVAL = 3'd6;
	localparam logic [2:0] REG_FAST_INTERVAL = 3'd7;

	localparam logic [3:0] M_PRESS       = 4'd0;
	localparam logic [3:0] M_RED         = 4'd1;
	localparam logic [3:0] M_VIOLET      = 4'd7;
	localparam logic [3:0] M_START_FLASH = 4'd8;
	localparam logic [3:0] M_FLASH_ON    = 4'd9;
	localparam logic [3:0] M_FLASH_OFF   = 4'd10;
	localparam logic [3:0] M_DEPRESS     = 4'd11;

	localparam logic [23:0] WHITE = 24'hFFFFFF;

	function automatic logic [23:0] rainbow_color(input logic [2:0] idx);
		logic [23:0] c;
		case (idx)
			3'd0: c = 24'hFF0000;
			3'd1: c = 24'hFFA500;
			3'd2: c = 24'hFFFF00;
			3'd3: c = 24'h008000;
			3'd4: c = 24'h0000FF;
			3'd5: c = 24'h4B0082;
			3'd6: c = 24'hEE82EE;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction
endpackage

// ===== rtl/core/pressure_fill_burst_light_sequencer.sv =====
`timescale 1ns / 1ps
// Pressure fill / burst light sequencer.
// Input channel: one transaction per update tick (now_ms, sample_valid,
// pressure, widget_active), accepted when in_valid is high and in_stall low.
// Output channel: one paint transaction per tick (active, clear_all, paint,
// paint_start, paint_color, bursting), taken when out_valid high, out_stall low.
// Configuration: cfg_we / cfg_index / cfg_data, to be written only while idle;
// the user must keep to this, the block itself does not enforce it. Each tick
// runs through a small sequencer that shares one serial divider. Ticks needing
// no division pass S_EVAL, S_MAIN and S_EMIT into the result register. A
// rainbow tick that maps the step interval, or a bar tick, adds one division;
// no tick needs both.
// The next tick is accepted once the result register is loaded, even while
// the receiver stalls; a stalled result holds until taken, and a further
// finished result waits in the sequencer until the result register frees.
// Reset clears all mode state and loads the register defaults.
module pressure_fill_burst_light_sequencer #(
	parameter int unsigned ROWS            = pfbls_pkg::ROWS_DEF,
	parameter int unsigned FLASH_PERIOD_MS = pfbls_pkg::FLASH_PERIOD_MS_DEF,
	parameter int unsigned BURST_TIME_MS   = pfbls_pkg::BURST_TIME_MS_DEF,
	parameter int unsigned FLASH_TIME_MS   = pfbls_pkg::FLASH_TIME_MS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic        sample_valid,
	input  logic [9:0]  pressure,
	input  logic        widget_active,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        active,
	output logic        clear_all,
	output logic        paint,
	output logic [7:0]  paint_start,
	output logic [23:0] paint_color,
	output logic        bursting
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1; // rainbow interval decision
	localparam logic [2:0] S_IWAIT = 3'd2;
	localparam logic [2:0] S_MAIN  = 3'd3;
	localparam logic [2:0] S_BWAIT = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;
	localparam int unsigned NW = 27;

	logic [2:0] st_q;
	// configuration
	logic [9:0]  low_q, burst_q, flash_q;
	logic [23:0] fill_q;
	logic [24:0] drain_q;
	logic [7:0]  step_q;
	logic [15:0] slow_q, fast_q;
	// mode state
	logic [3:0]  mode_q;
	logic [7:0]  front_q;
	logic [31:0] next_q, bend_q, fend_q;
	logic [15:0] ivl_q;
	logic        prio_q;
	logic        rain_q; // tick entered in a rainbow mode
	// captured tick
	logic [31:0] now_q;
	logic        got_q, act_q;
	logic [9:0]  p_q;
	// pending result
	logic        r_act_q, r_clr_q, r_pnt_q;
	logic [7:0]  r_start_q;
	logic [23:0] r_col_q;
	logic        bar_neg_q; // bar numerator negative: level clamps to zero
	// output register
	logic        ov_q, o_act_q, o_clr_q, o_pnt_q, o_bur_q;
	logic [7:0]  o_start_q;
	logic [23:0] o_col_q;

	logic          d_start, d_done;
	logic [NW-1:0] d_num;
	logic [9:0]    d_den;
	logic [NW-1:0] d_quo;

	pfbls_div #(.NW(NW), .DW(10)) u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .num(d_num), .den(d_den),
		.done(d_done), .quo(d_quo)
	);

	function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// interval map operands: |slow-fast| * |p-burst| over flash-burst
	logic signed [16:0] sf_diff;
	logic signed [10:0] pb_diff, mr_diff, pl_diff, bl_diff;
	logic [15:0] sf_mag;
	logic [9:0]  pb_mag, pl_mag;
	logic        ivl_neg;
	assign sf_diff = $signed({1'b0, slow_q}) - $signed({1'b0, fast_q});
	assign pb_diff = $signed({1'b0, p_q}) - $signed({1'b0, burst_q});
	assign mr_diff = $signed({1'b0, flash_q}) - $signed({1'b0, burst_q});
	assign pl_diff = $signed({1'b0, p_q}) - $signed({1'b0, low_q});
	assign bl_diff = $signed({1'b0, burst_q}) - $signed({1'b0, low_q});
	assign sf_mag  = sf_diff[16] ? 16'(-sf_diff) : sf_diff[15:0];
	assign pb_mag  = pb_diff[10] ? 10'(-pb_diff) : pb_diff[9:0];
	assign pl_mag  = pl_diff[9:0];
	// product sign differs from divisor sign -> subtracted term is negative
	assign ivl_neg = sf_diff[16] ^ pb_diff[10] ^ mr_diff[10];

	// Mode-path decision, shared by S_EVAL and S_IWAIT.
	logic        need_ivl_div, mr_zero;
	logic [9:0]  mr_mag;
	assign mr_zero = (mr_diff == '0);
	assign mr_mag  = mr_diff[10] ? 10'(-mr_diff) : mr_diff[9:0];
	assign need_ivl_div = !mr_zero && (sf_diff != '0) && (pb_diff != '0);

	// interval result from quotient, then clamp high to slow, low to fast
	logic signed [33:0] ivl_v;
	logic [15:0] ivl_new;
	always_comb begin
		if (!need_ivl_div)
			ivl_v = $signed({18'd0, slow_q});
		else if (ivl_neg)
			ivl_v = $signed({18'd0, slow_q}) + $signed({7'd0, d_quo});
		else
			ivl_v = $signed({18'd0, slow_q}) - $signed({7'd0, d_quo});
		if (ivl_v > $signed({18'd0, slow_q})) ivl_v = $signed({18'd0, slow_q});
		if (ivl_v < $signed({18'd0, fast_q})) ivl_v = $signed({18'd0, fast_q});
		ivl_new = ivl_v[15:0];
	end

	// bar start from quotient: ROWS - clamp(lvl)
	logic [7:0] bar_from_quo;
	always_comb begin
		if (bar_neg_q)
			bar_from_quo = 8'(ROWS);
		else if (d_quo >= NW'(ROWS))
			bar_from_quo = 8'd0;
		else
			bar_from_quo = 8'(ROWS - 32'(d_quo));
	end

	// rainbow step
	logic signed [9:0] f_diff;
	logic [7:0] f_new;
	logic       rb_end; // last violet step ends the burst
	assign f_diff = $signed({2'b0, front_q}) - $signed({2'b0, step_q});
	assign f_new  = f_diff[9] ? 8'd0 : f_diff[7:0];
	assign rb_end = (mode_q == pfbls_pkg::M_VIOLET) && (f_new == 8'd0)
		&& ((got_q && p_q <= burst_q) || !time_before(now_q, bend_q));

	logic take_in, out_free;
	assign in_stall = (st_q != S_IDLE);
	assign take_in  = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;

	logic bar_div_go;   // launch bar division in S_MAIN
	logic [9:0] bar_p_mag;

	// sequencer
	always_comb begin
		d_start = 1'b0;
		d_num = NW'(sf_mag) * NW'(pb_mag);
		d_den = mr_mag;
		if (st_q == S_EVAL && mode_q >= pfbls_pkg::M_RED && mode_q <= pfbls_pkg::M_VIOLET
				&& act_q && got_q && !(p_q > flash_q) && need_ivl_div)
			d_start = 1'b1;
		if (bar_div_go) begin
			d_start = 1'b1;
			d_num = NW'(ROWS) * NW'(bar_p_mag);
			d_den = bl_diff[9:0];
		end
	end

	// bar needed in S_MAIN: pressurizing fill or drain display
	logic main_bar, main_bar_pos, drain_full;
	assign drain_full = (p_q >= burst_q);
	always_comb begin
		main_bar = 1'b0;
		if (mode_q == pfbls_pkg::M_PRESS && got_q && act_q && !(p_q > burst_q))
			main_bar = 1'b1;
		if (mode_q == pfbls_pkg::M_DEPRESS && act_q && got_q && !(p_q <= low_q)
				&& drain_q[24] && !drain_full)
			main_bar = 1'b1;
	end
	// bar divisor is positive only when burst > low; otherwise start 0, no divide
	assign main_bar_pos = !bl_diff[10] && (bl_diff != '0);
	assign bar_div_go   = (st_q == S_MAIN) && main_bar && main_bar_pos && !pl_diff[10];
	assign bar_p_mag    = pl_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			low_q     <= 10'd100;
			burst_q   <= 10'd700;
			flash_q   <= 10'd900;
			fill_q    <= 24'd255;
			drain_q   <= 25'd0;
			step_q    <= 8'd8;
			slow_q    <= 16'd100;
			fast_q    <= 16'd20;
			mode_q    <= pfbls_pkg::M_PRESS;
			front_q   <= '0;
			next_q    <= '0;
			bend_q    <= '0;
			fend_q    <= '0;
			ivl_q     <= '0;
			prio_q    <= 1'b0;
			rain_q    <= 1'b0;
			ov_q      <= 1'b0;
			r_act_q   <= 1'b0;
			r_clr_q   <= 1'b0;
			r_pnt_q   <= 1'b0;
			r_start_q <= 8'd0;
			r_col_q   <= 24'd0;
			bar_neg_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfbls_pkg::REG_LOW_CUTOFF:    low_q   <= cfg_data[9:0];
					pfbls_pkg::REG_BURST_LEVEL:   burst_q <= cfg_data[9:0];
					pfbls_pkg::REG_FLASH_LEVEL:   flash_q <= cfg_data[9:0];
					pfbls_pkg::REG_FILL_COLOR:    fill_q  <= cfg_data[23:0];
					pfbls_pkg::REG_DRAIN_COLOR:   drain_q <= cfg_data;
					pfbls_pkg::REG_STEP_ROWS:     step_q  <= cfg_data[7:0];
					pfbls_pkg::REG_SLOW_INTERVAL: slow_q  <= cfg_data[15:0];
					pfbls_pkg::REG_FAST_INTERVAL: fast_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			// load the result when the sequencer emits, drop it once taken
			if (st_q == S_EMIT && out_free)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (take_in) begin
						st_q      <= S_EVAL;
						r_act_q   <= widget_active && !(sample_valid && pressure <= low_q);
						r_clr_q   <= 1'b0;
						r_pnt_q   <= 1'b0;
						r_start_q <= 8'd0;
						r_col_q   <= 24'd0;
						bar_neg_q <= 1'b0;
					end
				end
				S_EVAL: begin
					rain_q <= (mode_q >= pfbls_pkg::M_RED && mode_q <= pfbls_pkg::M_VIOLET);
					if (mode_q >= pfbls_pkg::M_RED && mode_q <= pfbls_pkg::M_VIOLET
							&& act_q && got_q) begin
						if (p_q > flash_q) begin
							mode_q <= pfbls_pkg::M_START_FLASH;
							st_q   <= S_MAIN;
						end else if (need_ivl_div) begin
							st_q <= S_IWAIT;
						end else begin
							ivl_q <= ivl_new;
							st_q  <= S_MAIN;
						end
					end else begin
						st_q <= S_MAIN;
					end
				end
				S_IWAIT: begin
					if (d_done) begin
						ivl_q <= ivl_new;
						st_q  <= S_MAIN;
					end
				end
				S_MAIN: begin
					st_q <= bar_div_go ? S_BWAIT : S_EMIT;
					if (rain_q && time_before(now_q, next_q)) begin
						// step not due: report active, paint nothing
						r_act_q <= 1'b1;
					end else begin
						unique case (mode_q)
							pfbls_pkg::M_PRESS: begin
								if (got_q && act_q) begin
									r_clr_q <= 1'b1;
									if (p_q > burst_q) begin
										bend_q  <= now_q + 32'(BURST_TIME_MS);
										front_q <= 8'(ROWS);
										ivl_q   <= slow_q;
										next_q  <= now_q;
										mode_q  <= pfbls_pkg::M_RED;
									end else begin
										r_pnt_q   <= 1'b1;
										r_col_q   <= fill_q;
										r_start_q <= main_bar_pos ? 8'(ROWS) : 8'd0;
										bar_neg_q <= pl_diff[10];
									end
								end
							end
							pfbls_pkg::M_START_FLASH: begin
								fend_q <= now_q + 32'(FLASH_TIME_MS);
								next_q <= now_q;
								mode_q <= pfbls_pkg::M_FLASH_ON;
							end
							pfbls_pkg::M_FLASH_ON: begin
								if (!time_before(now_q, next_q)) begin
									r_pnt_q   <= 1'b1;
									r_start_q <= 8'd0;
									r_col_q   <= pfbls_pkg::WHITE;
									next_q    <= now_q + 32'(FLASH_PERIOD_MS);
									mode_q    <= pfbls_pkg::M_FLASH_OFF;
								end
							end
							pfbls_pkg::M_FLASH_OFF: begin
								if (!time_before(now_q, next_q)) begin
									r_clr_q <= 1'b1;
									if (time_before(now_q, fend_q)) begin
										next_q <= now_q + 32'(FLASH_PERIOD_MS);
										mode_q <= pfbls_pkg::M_FLASH_ON;
									end else begin
										prio_q <= 1'b0;
										mode_q <= pfbls_pkg::M_DEPRESS;
									end
								end
							end
							pfbls_pkg::M_DEPRESS: begin
								if (!act_q) begin
									mode_q <= pfbls_pkg::M_PRESS;
								end else if (got_q) begin
									if (p_q <= low_q) begin
										r_act_q <= 1'b0;
										mode_q  <= pfbls_pkg::M_PRESS;
									end else if (drain_q[24]) begin
										r_clr_q   <= 1'b1;
										r_pnt_q   <= 1'b1;
										r_col_q   <= drain_q[23:0];
										bar_neg_q <= pl_diff[10];
										if (drain_full)
											r_start_q <= 8'd0;
										else
											r_start_q <= main_bar_pos ? 8'(ROWS) : 8'd0;
									end else begin
										r_act_q <= 1'b0;
									end
								end
							end
							default: begin
								// rainbow modes: advance the front one step
								if (mode_q == pfbls_pkg::M_RED)
									prio_q <= 1'b1;
								else if (rb_end)
									prio_q <= 1'b0;
								r_pnt_q   <= !rb_end;
								r_clr_q   <= rb_end;
								r_start_q <= f_new;
								r_col_q   <= rb_end ? 24'd0
									: pfbls_pkg::rainbow_color(3'(mode_q - 4'd1));
								next_q    <= now_q + 32'(ivl_q);
								front_q   <= (f_new == 8'd0) ? 8'(ROWS) : f_new;
								if (f_new == 8'd0) begin
									if (mode_q != pfbls_pkg::M_VIOLET)
										mode_q <= mode_q + 4'd1;
									else if (rb_end)
										mode_q <= pfbls_pkg::M_DEPRESS;
									else
										mode_q <= pfbls_pkg::M_RED;
								end
							end
						endcase
					end
				end
				S_BWAIT: begin
					if (d_done) begin
						r_start_q <= bar_from_quo;
						st_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold until the result register frees
					if (out_free) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// tick capture and result register
	always_ff @(posedge clk) begin
		if (take_in) begin
			now_q <= now_ms;
			got_q <= sample_valid;
			p_q   <= pressure;
			act_q <= widget_active && !(sample_valid && pressure <= low_q);
		end
		if (st_q == S_EMIT && out_free) begin
			o_act_q   <= r_act_q;
			o_clr_q   <= r_clr_q;
			o_pnt_q   <= r_pnt_q;
			o_start_q <= r_pnt_q ? r_start_q : 8'd0;
			o_col_q   <= r_pnt_q ? r_col_q : 24'd0;
			o_bur_q   <= prio_q;
		end
	end

	assign out_valid   = ov_q;
	assign active      = o_act_q;
	assign clear_all   = o_clr_q;
	assign paint       = o_pnt_q;
	assign paint_start = o_start_q;
	assign paint_color = o_col_q;
	assign bursting    = o_bur_q;
endmodule

// ===== rtl/core/pfbls_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module pfbls_div #(
	parameter int unsigned NW = 27,
	parameter int unsigned DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== rtl/core/pfbls_checker.sv =====
`timescale 1ns / 1ps
module pfbls_assert (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        clear_all,
	input logic        paint,
	input logic [7:0]  paint_start,
	input logic [23:0] paint_color
);
	// ticks are never accepted back to back
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("back-to-back accept");
	// no result without a preceding accept
	a_out_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without tick");
	// unpainted results carry zero payload
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !paint) |-> (paint_start == 8'd0 && paint_color == 24'd0))
		else $error("payload without paint");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(clear_all) && $stable(paint)))
		else $error("stalled result changed");
endmodule

bind pressure_fill_burst_light_sequencer pfbls_assert u_pfbls_assert (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .clear_all(clear_all),
	.paint(paint), .paint_start(paint_start), .paint_color(paint_color)
);
